// ----- src/gmt_pkg.sv -----
package gmt_pkg;

  localparam int unsigned Entries = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CntW    = 4;
  localparam int unsigned GrpW    = 16;
  localparam int unsigned AdrW    = 16;

  localparam logic [1:0] CmdLookup   = 2'd0;
  localparam logic [1:0] CmdRegister = 2'd1;
  localparam logic [1:0] CmdRemove   = 2'd2;
  localparam logic [1:0] CmdGet      = 2'd3;

  typedef struct packed {
    logic            valid;
    logic [GrpW-1:0] grp;
    logic [AdrW-1:0] adr;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pull;
  } cell_ctrl_t;

endpackage

// ----- src/group_membership_table.sv -----
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one command per cycle while in_ready_o is high. Cells compare in
// parallel and shift one place together; on a remove, only from the match on.
// Input ready is high while the output register is empty or being emptied.
// Reset: asynchronous, active low; clears the count, all cell valid bits and
// the output valid; stored pairs stay undefined until written.
module group_membership_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [gmt_pkg::GrpW-1:0]  group_id_i,
  input  logic [gmt_pkg::AdrW-1:0]  link_address_i,
  input  logic [gmt_pkg::PosW-1:0]  position_query_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [gmt_pkg::PosW-1:0]  position_o,
  output logic [gmt_pkg::GrpW-1:0]  out_group_o,
  output logic [gmt_pkg::AdrW-1:0]  out_address_o,
  output logic                      status_o,
  output logic [gmt_pkg::CntW-1:0]  entry_count_o
);

  localparam logic [gmt_pkg::CntW-1:0] Full = gmt_pkg::CntW'(gmt_pkg::Entries);

  gmt_pkg::entry_t     entries [gmt_pkg::Entries];
  gmt_pkg::entry_t     prevs   [gmt_pkg::Entries];
  gmt_pkg::entry_t     nexts   [gmt_pkg::Entries];
  gmt_pkg::cell_ctrl_t ctrls   [gmt_pkg::Entries];
  logic [gmt_pkg::Entries-1:0] match;
  logic [gmt_pkg::Entries-1:0] after_mask;
  logic [gmt_pkg::Entries-1:0] valid_vec;
  logic [gmt_pkg::Entries-1:0] expected_valid;

  logic                      in_fire;
  logic                      any_match;
  logic [gmt_pkg::PosW-1:0]  match_idx;
  logic [gmt_pkg::PosW-1:0]  sel_idx;
  gmt_pkg::entry_t           sel_entry;
  logic                      get_hit;
  logic                      do_push;
  logic                      do_pull;

  logic [gmt_pkg::CntW-1:0]  count_q, count_d;
  logic                      out_valid_q;
  logic                      hit_q, hit_d;
  logic [gmt_pkg::PosW-1:0]  pos_q, pos_d;
  logic [gmt_pkg::GrpW-1:0]  og_q, og_d;
  logic [gmt_pkg::AdrW-1:0]  oa_q, oa_d;
  logic                      st_q, st_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  for (genvar i = 0; i < gmt_pkg::Entries; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prevs[i].valid = 1'b1;
      assign prevs[i].grp   = group_id_i;
      assign prevs[i].adr   = link_address_i;
    end else begin : g_body
      assign prevs[i] = entries[i-1];
    end
    if (i == gmt_pkg::Entries - 1) begin : g_tail
      assign nexts[i].valid = 1'b0;
      assign nexts[i].grp   = entries[i].grp;
      assign nexts[i].adr   = entries[i].adr;
    end else begin : g_inner
      assign nexts[i] = entries[i+1];
    end
    assign ctrls[i].push = do_push;
    assign ctrls[i].pull = do_pull && after_mask[i];
    assign valid_vec[i]  = entries[i].valid;
    assign expected_valid[i] = (gmt_pkg::CntW'(i) < count_q);

    gmt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrls[i]),
      .prev_i    (prevs[i]),
      .next_i    (nexts[i]),
      .key_grp_i (group_id_i),
      .key_adr_i (link_address_i),
      .entry_o   (entries[i]),
      .match_o   (match[i])
    );
  end

  always_comb begin
    match_idx = '0;
    for (int i = gmt_pkg::Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = gmt_pkg::PosW'(i);
      end
    end
  end

  always_comb begin
    after_mask[0] = match[0];
    for (int i = 1; i < gmt_pkg::Entries; i++) begin
      after_mask[i] = after_mask[i-1] || match[i];
    end
  end

  assign any_match = |match;
  assign get_hit   = {1'b0, position_query_i} < count_q;
  assign sel_idx   = (cmd_i == gmt_pkg::CmdGet) ? position_query_i : match_idx;
  assign sel_entry = entries[sel_idx];

  assign do_push = in_fire && (cmd_i == gmt_pkg::CmdRegister) && !any_match
                   && (count_q < Full);
  assign do_pull = in_fire && (cmd_i == gmt_pkg::CmdRemove) && any_match;

  always_comb begin
    count_d = count_q;
    hit_d   = 1'b0;
    pos_d   = '0;
    og_d    = '0;
    oa_d    = '0;
    st_d    = 1'b0;
    case (cmd_i)
      gmt_pkg::CmdLookup: begin
        if (any_match) begin
          hit_d = 1'b1;
          pos_d = match_idx;
          og_d  = sel_entry.grp;
          oa_d  = sel_entry.adr;
        end
      end
      gmt_pkg::CmdRegister: begin
        if (!any_match) begin
          if (count_q < Full) begin
            count_d = count_q + 1'b1;
          end else begin
            st_d = 1'b1;
          end
        end
      end
      gmt_pkg::CmdRemove: begin
        if (any_match) begin
          hit_d   = 1'b1;
          pos_d   = match_idx;
          count_d = count_q - 1'b1;
        end
      end
      gmt_pkg::CmdGet: begin
        if (get_hit) begin
          hit_d = 1'b1;
          pos_d = position_query_i;
          og_d  = sel_entry.grp;
          oa_d  = sel_entry.adr;
        end
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
      og_q  <= og_d;
      oa_q  <= oa_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign position_o    = pos_q;
  assign out_group_o   = og_q;
  assign out_address_o = oa_q;
  assign status_o      = st_q;
  assign entry_count_o = count_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count beyond table size");

  a_valid_therm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec == expected_valid)
    else $error("cell valid bits disagree with entry count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (entry_count_o == Full))
    else $error("full status with room left");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted transaction gave no result");

endmodule

// ----- src/gmt_cell.sv -----
module gmt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gmt_pkg::cell_ctrl_t       ctrl_i,
  input  gmt_pkg::entry_t           prev_i,
  input  gmt_pkg::entry_t           next_i,
  input  logic [gmt_pkg::GrpW-1:0]  key_grp_i,
  input  logic [gmt_pkg::AdrW-1:0]  key_adr_i,
  output gmt_pkg::entry_t           entry_o,
  output logic                      match_o
);

  logic                     valid_q, valid_d;
  logic [gmt_pkg::GrpW-1:0] grp_q, grp_d;
  logic [gmt_pkg::AdrW-1:0] adr_q, adr_d;

  always_comb begin
    valid_d = valid_q;
    grp_d   = grp_q;
    adr_d   = adr_q;
    if (ctrl_i.push) begin
      valid_d = prev_i.valid;
      grp_d   = prev_i.grp;
      adr_d   = prev_i.adr;
    end else if (ctrl_i.pull) begin
      valid_d = next_i.valid;
      grp_d   = next_i.grp;
      adr_d   = next_i.adr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    adr_q <= adr_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.grp   = grp_q;
  assign entry_o.adr   = adr_q;
  assign match_o = valid_q && (grp_q == key_grp_i) && (adr_q == key_adr_i);

endmodule

// ----- tb/sv/group_membership_table_test.sv -----
`timescale 1ns / 1ps

class membership_scoreboard;

  typedef struct packed {
    logic                     hit;
    logic [gmt_pkg::PosW-1:0] position;
    logic [gmt_pkg::GrpW-1:0] grp;
    logic [gmt_pkg::AdrW-1:0] adr;
    logic                     status;
    logic [gmt_pkg::CntW-1:0] count;
  } outcome_t;

  gmt_pkg::entry_t held[gmt_pkg::Entries];
  int unsigned     held_count;
  outcome_t        pending_outcomes[$];
  int unsigned     errors;
  int unsigned     results_seen;

  function new();
    held_count   = 0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function int find_pair(logic [gmt_pkg::GrpW-1:0] grp, logic [gmt_pkg::AdrW-1:0] adr);
    for (int i = 0; i < held_count; i++) begin
      if (held[i].grp == grp && held[i].adr == adr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function void note_command(logic [1:0] cmd, logic [gmt_pkg::GrpW-1:0] grp,
                             logic [gmt_pkg::AdrW-1:0] adr,
                             logic [gmt_pkg::PosW-1:0] pq);
    outcome_t r;
    int       idx;
    r   = '0;
    idx = find_pair(grp, adr);
    case (cmd)
      gmt_pkg::CmdLookup: begin
        if (idx >= 0) begin
          r.hit      = 1'b1;
          r.position = idx[gmt_pkg::PosW-1:0];
          r.grp      = held[idx].grp;
          r.adr      = held[idx].adr;
        end
      end
      gmt_pkg::CmdRegister: begin
        if (idx < 0) begin
          if (held_count >= gmt_pkg::Entries) begin
            r.status = 1'b1;
          end else begin
            for (int i = held_count; i > 0; i--) begin
              held[i] = held[i-1];
            end
            held[0] = '{valid: 1'b1, grp: grp, adr: adr};
            held_count++;
          end
        end
      end
      gmt_pkg::CmdRemove: begin
        if (idx >= 0) begin
          r.hit      = 1'b1;
          r.position = idx[gmt_pkg::PosW-1:0];
          for (int i = idx; i + 1 < held_count; i++) begin
            held[i] = held[i+1];
          end
          held_count--;
          held[held_count].valid = 1'b0;
        end
      end
      default: begin
        if (pq < held_count) begin
          r.hit      = 1'b1;
          r.position = pq;
          r.grp      = held[pq].grp;
          r.adr      = held[pq].adr;
        end
      end
    endcase
    r.count = held_count[gmt_pkg::CntW-1:0];
    pending_outcomes.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  function void check_result(logic hit, logic [gmt_pkg::PosW-1:0] position,
                             logic [gmt_pkg::GrpW-1:0] grp,
                             logic [gmt_pkg::AdrW-1:0] adr, logic status,
                             logic [gmt_pkg::CntW-1:0] count);
    outcome_t e;
    results_seen++;
    if (pending_outcomes.size() == 0) begin
      $display("%0t unexpected result: hit %0h position %0h group %0h address %0h",
               $time, hit, position, grp, adr);
      errors++;
      return;
    end
    e = pending_outcomes.pop_front();
    compare_field("hit", 16'(e.hit), 16'(hit));
    compare_field("position", 16'(e.position), 16'(position));
    compare_field("out_group", e.grp, grp);
    compare_field("out_address", e.adr, adr);
    compare_field("status", 16'(e.status), 16'(status));
    compare_field("entry_count", 16'(e.count), 16'(count));
  endfunction

endclass

module group_membership_table_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned PoolSize    = 12;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               cmd_i            = gmt_pkg::CmdLookup;
  logic [gmt_pkg::GrpW-1:0] group_id_i       = '0;
  logic [gmt_pkg::AdrW-1:0] link_address_i   = '0;
  logic [gmt_pkg::PosW-1:0] position_query_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i      = 1'b0;
  logic                     hit_o;
  logic [gmt_pkg::PosW-1:0] position_o;
  logic [gmt_pkg::GrpW-1:0] out_group_o;
  logic [gmt_pkg::AdrW-1:0] out_address_o;
  logic                     status_o;
  logic [gmt_pkg::CntW-1:0] entry_count_o;

  membership_scoreboard     book = new();
  int unsigned              cycles = 0;
  logic [gmt_pkg::GrpW-1:0] pool_grp[PoolSize];
  logic [gmt_pkg::AdrW-1:0] pool_adr[PoolSize];

  group_membership_table u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .group_id_i,
    .link_address_i,
    .position_query_i,
    .out_valid_o,
    .out_ready_i,
    .hit_o,
    .position_o,
    .out_group_o,
    .out_address_o,
    .status_o,
    .entry_count_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_result(hit_o, position_o, out_group_o, out_address_o, status_o,
                        entry_count_o);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [gmt_pkg::GrpW-1:0] grp,
                              logic [gmt_pkg::AdrW-1:0] adr,
                              logic [gmt_pkg::PosW-1:0] pq, bit no_gap);
    int unsigned gap;
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    group_id_i       <= grp;
    link_address_i   <= adr;
    position_query_i <= pq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_command(cmd, grp, adr, pq);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, stretches of full readiness, one long hold-off
  initial begin
    bit          held_off;
    int unsigned stall;
    held_off = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held_off && book.results_seen >= 150) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        repeat (64) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned              r;
    int unsigned              k;
    logic [1:0]               cmd;
    logic [gmt_pkg::GrpW-1:0] grp;
    logic [gmt_pkg::AdrW-1:0] adr;
    bit                       burst;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(gmt_pkg::CmdLookup,   16'h1234, 16'h5678, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdGet,      16'h0000, 16'h0000, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRemove,   16'h0000, 16'h0000, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'h0000, 16'h0000, 3'd7, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'hFFFF, 16'h0000, 3'd0, 1'b1);
    send_command(gmt_pkg::CmdRegister, 16'h0000, 16'hFFFF, 3'd0, 1'b1);
    send_command(gmt_pkg::CmdRegister, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'hAAAA, 16'h5555, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'h5555, 16'hAAAA, 3'd0, 1'b1);
    send_command(gmt_pkg::CmdRegister, 16'h1234, 16'h5678, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'h8001, 16'h0001, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'h0F0F, 16'hF0F0, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdLookup,   16'h0000, 16'h0000, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdLookup,   16'h8001, 16'h0001, 3'd0, 1'b1);
    send_command(gmt_pkg::CmdGet,      16'h0000, 16'h0000, 3'd7, 1'b0);
    send_command(gmt_pkg::CmdGet,      16'hFFFF, 16'hFFFF, 3'd3, 1'b0);
    send_command(gmt_pkg::CmdRemove,   16'h5555, 16'hAAAA, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdGet,      16'h0000, 16'h0000, 3'd7, 1'b1);
    send_command(gmt_pkg::CmdRemove,   16'h5555, 16'hAAAA, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdLookup,   16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRegister, 16'h0F0F, 16'hF0F0, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdRemove,   16'h0000, 16'h0000, 3'd0, 1'b1);
    send_command(gmt_pkg::CmdRemove,   16'h0F0F, 16'hF0F0, 3'd0, 1'b0);
    send_command(gmt_pkg::CmdLookup,   16'h1234, 16'h0000, 3'd0, 1'b0);
    drain();

    for (int i = 0; i < PoolSize; i++) begin
      pool_grp[i] = gmt_pkg::GrpW'($urandom_range(0, 16'hFFFF));
      pool_adr[i] = gmt_pkg::AdrW'($urandom_range(0, 16'hFFFF));
    end

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain();
      burst = ((i / 64) % 3) == 1;
      r = $urandom_range(0, 99);
      if (r < 35)      cmd = gmt_pkg::CmdRegister;
      else if (r < 60) cmd = gmt_pkg::CmdRemove;
      else if (r < 80) cmd = gmt_pkg::CmdLookup;
      else             cmd = gmt_pkg::CmdGet;
      k = $urandom_range(0, PoolSize - 1);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        grp = pool_grp[k];
        adr = pool_adr[k];
      end else if (r < 90) begin
        grp = pool_grp[k];
        adr = gmt_pkg::AdrW'($urandom_range(0, 16'hFFFF));
      end else begin
        grp = gmt_pkg::GrpW'($urandom_range(0, 16'hFFFF));
        adr = gmt_pkg::AdrW'($urandom_range(0, 16'hFFFF));
      end
      send_command(cmd, grp, adr, 3'($urandom_range(0, 7)), burst);
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
